// ===== rtl/lphi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphi_pkg
// Shared types and constants of the linear-probe hash insert core.
// ----------------------------------------------------------------------------
package lphi_pkg;

  localparam int KEY_WIDTH       = 64;
  localparam int IN_PAY_WIDTH    = 32;
  localparam int SIZE_WIDTH      = 11;
  localparam int SLOT_WIDTH      = 10;
  localparam int PROBE_WIDTH     = 10;
  localparam int STATUS_WIDTH    = 2;
  localparam int MOD_DIGIT       = 4;

  localparam int DEF_TABLE_DEPTH   = 1024;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  localparam logic [SIZE_WIDTH-1:0]  SIZE_RESET = 11'd1024;
  localparam logic [PROBE_WIDTH-1:0] PROBES_MAX = 10'd1023;

  localparam int IN_DATA_WIDTH  = KEY_WIDTH + IN_PAY_WIDTH;
  localparam int OUT_FIELD_BITS = STATUS_WIDTH + SLOT_WIDTH + PROBE_WIDTH;
  localparam int OUT_DATA_WIDTH = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STAT_STORED  = 2'd0,
    STAT_UPDATED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_SKIPPED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_ZERO
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic pay_we;
  } tbl_ctl_t;

endpackage

// ===== rtl/linear_probe_hash_insert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_core
// Open-addressed hash table insert with linear probing over slot memories.
// ----------------------------------------------------------------------------
// After reset the core sweeps every slot of the key memory to zero, one slot per
// cycle, and takes no input beat until the sweep ends. An insert then finds its
// home slot in the remainder unit (four key bits a cycle) and examines slots in
// turn through the single key memory read port, since each probe issues the next
// read while comparing the current key; no new input is taken until its result
// is registered. A zero key presents its result and frees the input together,
// once the output can take the result.
module linear_probe_hash_insert_core
  import lphi_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [SIZE_WIDTH-1:0]     cfg_data,   // table_size
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_DATA_WIDTH-1:0]  in_tdata,   // hashcode[63:0], payload[95:64]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DATA_WIDTH-1:0] out_tdata   // status[1:0], slot[11:2], probes[21:12]
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = AW + 1;

  state_t                    state_r, state_nxt;
  logic [SIZE_WIDTH-1:0]     table_size_r;
  logic [SW-1:0]             eff_size;
  logic [AW-1:0]             clr_r, clr_nxt;
  logic [AW-1:0]             pos_r, pos_nxt;
  logic [AW-1:0]             home_r, home_nxt;
  logic [SW-1:0]             steps_r, steps_nxt;
  logic [KEY_WIDTH-1:0]      key_r;
  logic [PAYLOAD_WIDTH-1:0]  pay_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_DATA_WIDTH-1:0] out_data_r, out_data_nxt;

  logic [KEY_WIDTH-1:0]      in_key;
  logic                      in_fire;
  logic                      mod_start;
  logic                      mod_done;
  logic [AW-1:0]             mod_rem;
  tbl_ctl_t                  tbl_ctl;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic [KEY_WIDTH-1:0]      wr_key;
  logic [KEY_WIDTH-1:0]      rd_key;
  logic                      can_emit;
  logic [SW-1:0]             pos_inc;
  logic [AW-1:0]             pos_wrap;
  logic [SW-1:0]             steps_inc;
  logic [PROBE_WIDTH-1:0]    probes_v;
  logic [PROBE_WIDTH-1:0]    probes_full;

  assign cfg_ready = 1'b1;
  assign in_key    = in_tdata[KEY_WIDTH-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign mod_start = in_fire && (in_key != '0);
  assign can_emit  = !out_valid_r || out_tready;

  always_comb begin
    if (table_size_r == '0) begin
      eff_size = SW'(1);
    end else if (32'(table_size_r) > 32'(TABLE_DEPTH)) begin
      eff_size = SW'(TABLE_DEPTH);
    end else begin
      eff_size = SW'(table_size_r);
    end
  end

  assign pos_inc     = {1'b0, pos_r} + 1'b1;
  assign pos_wrap    = (pos_inc >= eff_size) ? '0 : pos_inc[AW-1:0];
  assign steps_inc   = steps_r + 1'b1;
  assign probes_v    = (32'(steps_r) > 32'(PROBES_MAX)) ? PROBES_MAX
                                                        : PROBE_WIDTH'(steps_r);
  assign probes_full = (32'(steps_inc) > 32'(PROBES_MAX)) ? PROBES_MAX
                                                          : PROBE_WIDTH'(steps_inc);

  assign wr_addr = (state_r == ST_CLEAR) ? clr_r : pos_r;
  assign wr_key  = (state_r == ST_CLEAR) ? '0 : key_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    home_nxt      = home_r;
    steps_nxt     = steps_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    tbl_ctl       = '0;
    rd_addr       = pos_r;
    case (state_r)
      ST_CLEAR: begin
        tbl_ctl.key_we = 1'b1;
        clr_nxt        = clr_r + 1'b1;
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_key == '0) ? ST_ZERO : ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          tbl_ctl.rd_en = 1'b1;
          rd_addr       = mod_rem;
          pos_nxt       = mod_rem;
          home_nxt      = mod_rem;
          steps_nxt     = '0;
          state_nxt     = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (rd_key == key_r || rd_key == '0) begin
          if (can_emit) begin
            tbl_ctl.key_we = 1'b1;
            tbl_ctl.pay_we = 1'b1;
            out_valid_nxt  = 1'b1;
            out_data_nxt   = OUT_DATA_WIDTH'({probes_v, SLOT_WIDTH'(pos_r),
                             (rd_key == key_r) ? STAT_UPDATED : STAT_STORED});
            state_nxt      = ST_IDLE;
          end
        end else if (pos_wrap == home_r) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = OUT_DATA_WIDTH'({probes_full, SLOT_WIDTH'(home_r),
                            STAT_FULL});
            state_nxt     = ST_IDLE;
          end
        end else begin
          tbl_ctl.rd_en = 1'b1;
          rd_addr       = pos_wrap;
          pos_nxt       = pos_wrap;
          steps_nxt     = steps_inc;
        end
      end
      ST_ZERO: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_WIDTH'({PROBE_WIDTH'(0), SLOT_WIDTH'(0),
                          STAT_SKIPPED});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      table_size_r <= SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        table_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    home_r     <= home_nxt;
    steps_r    <= steps_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      key_r <= in_key;
      pay_r <= PAYLOAD_WIDTH'(64'(in_tdata[IN_DATA_WIDTH-1:KEY_WIDTH]));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  lphi_mod #(
    .AW (AW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_key),
    .divisor  (eff_size),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  lphi_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .PW    (PAYLOAD_WIDTH)
  ) u_table (
    .clk     (clk),
    .ctl     (tbl_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_pay  (pay_r),
    .rd_key  (rd_key)
  );

endmodule

// ===== rtl/lphi_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphi_mod
// Iterative remainder unit: 64-bit key modulo table size, four key bits
// per cycle by restoring compare-and-subtract.
// ----------------------------------------------------------------------------
module lphi_mod
  import lphi_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [KEY_WIDTH-1:0] dividend,
  input  logic [AW:0]          divisor,
  output logic                 done,
  output logic [AW-1:0]        rem
);

  localparam int NCHUNK = KEY_WIDTH / MOD_DIGIT;
  localparam int CW     = $clog2(NCHUNK);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [KEY_WIDTH-1:0] dvd_r;
  logic [AW:0]          div_r;
  logic [AW-1:0]        rem_r;
  logic [AW-1:0]        rem_nxt;
  logic [AW:0]          t_v;

  always_comb begin
    rem_nxt = rem_r;
    t_v     = '0;
    for (int i = 0; i < MOD_DIGIT; i++) begin
      t_v = {rem_nxt, dvd_r[KEY_WIDTH-1-i]};
      if (t_v >= div_r) begin
        t_v = t_v - div_r;
      end
      rem_nxt = t_v[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NCHUNK - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[KEY_WIDTH-MOD_DIGIT-1:0], {MOD_DIGIT{1'b0}}};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/lphi_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphi_table
// Slot storage: key memory with a registered read port and payload memory,
// each with one write port.
// ----------------------------------------------------------------------------
module lphi_table
  import lphi_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int PW    = 32
) (
  input  logic                 clk,
  input  tbl_ctl_t             ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [KEY_WIDTH-1:0] wr_key,
  input  logic [PW-1:0]        wr_pay,
  output logic [KEY_WIDTH-1:0] rd_key
);

  logic [KEY_WIDTH-1:0] key_mem [DEPTH];
  logic [PW-1:0]        pay_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (ctl.rd_en) begin
      rd_key <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pay_we) begin
      pay_mem[wr_addr] <= wr_pay;
    end
  end

endmodule

// ===== verif/tb_linear_probe_hash_insert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_insert_core
// Self-checking bench for the linear-probe hash insert core. A shadow key
// table predicts status, slot and probe count for every accepted record. The
// run covers directed corner cases, random phases over many table sizes, and
// a final pass that fills all slots so the probe count saturates.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_insert_core;
  import lphi_pkg::*;

  localparam int TABLE_DEPTH    = DEF_TABLE_DEPTH;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 40;
  localparam int RANDOM_PHASES  = 16;

  typedef struct packed {
    logic [IN_PAY_WIDTH-1:0] pay;
    logic [KEY_WIDTH-1:0]    key;
  } record_t;

  typedef struct {
    status_t                status;
    logic [SLOT_WIDTH-1:0]  slot;
    logic [PROBE_WIDTH-1:0] probes;
  } insert_result_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_BUSY} rx_mode_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [SIZE_WIDTH-1:0]     cfg_data   = '0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_DATA_WIDTH-1:0]  in_tdata   = '0;    // hashcode[63:0], payload[95:64]
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] out_tdata;          // status[1:0], slot[11:2], probes[21:12]

  logic [KEY_WIDTH-1:0]  table_keys [0:TABLE_DEPTH-1] = '{default: '0};
  logic [SIZE_WIDTH-1:0] table_size_q = SIZE_RESET;
  logic [KEY_WIDTH-1:0]  known_keys [$];

  record_t        pending_records [$];
  insert_result_t expected_inserts [$];
  int             records_in_flight = 0;
  int             error_count = 0;
  int             idle_cycles = 0;

  bit             in_took = 1'b0;
  record_t        drive_rec;
  int             burst_left = 1;
  int             gap_left = 0;
  rx_mode_t       rx_mode = RX_OPEN;
  int             rx_left = 0;
  insert_result_t want;
  logic [STATUS_WIDTH-1:0] got_status;
  logic [SLOT_WIDTH-1:0]   got_slot;
  logic [PROBE_WIDTH-1:0]  got_probes;

  linear_probe_hash_insert_core #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_WIDTH(DEF_PAYLOAD_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic insert_result_t insert_record(input logic [KEY_WIDTH-1:0] key);
    insert_result_t r;
    int unsigned span;
    int unsigned home;
    int unsigned pos;
    int unsigned steps;
    bit done;
    r.status = STAT_SKIPPED;
    r.slot   = '0;
    r.probes = '0;
    if (key == '0) return r;
    if (table_size_q == '0) span = 1;
    else if (table_size_q > TABLE_DEPTH) span = TABLE_DEPTH;
    else span = table_size_q;
    home     = int'(key % 64'(span));
    pos      = home;
    steps    = 0;
    done     = 1'b0;
    r.status = STAT_FULL;
    while (!done) begin
      if (table_keys[pos] == key) begin
        r.status = STAT_UPDATED;
        done = 1'b1;
      end else if (table_keys[pos] == '0) begin
        r.status = STAT_STORED;
        done = 1'b1;
      end else begin
        steps++;
        pos++;
        if (pos >= span) pos = 0;
        if (pos == home) done = 1'b1;
      end
    end
    r.probes = (steps > PROBES_MAX) ? PROBES_MAX : steps[PROBE_WIDTH-1:0];
    if (r.status == STAT_FULL) begin
      r.slot = home[SLOT_WIDTH-1:0];
    end else begin
      if (r.status == STAT_STORED) known_keys.push_back(key);
      table_keys[pos] = key;
      r.slot = pos[SLOT_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic [KEY_WIDTH-1:0] random_key();
    logic [KEY_WIDTH-1:0] k;
    case ($urandom_range(0, 15))
      0:          k = '0;
      1, 2, 3:    k = (known_keys.size() != 0) ?
                      known_keys[$urandom_range(0, known_keys.size() - 1)] : 64'd1;
      4, 5, 6, 7: k = 64'($urandom_range(1, 4095));
      default:    k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  function automatic logic [IN_PAY_WIDTH-1:0] random_payload();
    logic [IN_PAY_WIDTH-1:0] p;
    case ($urandom_range(0, 7))
      0:       p = '0;
      1:       p = '1;
      default: p = $urandom;
    endcase
    return p;
  endfunction

  task automatic queue_record(input logic [KEY_WIDTH-1:0] key,
                              input logic [IN_PAY_WIDTH-1:0] pay);
    record_t rec;
    rec.key = key;
    rec.pay = pay;
    pending_records.push_back(rec);
    records_in_flight++;
  endtask

  task automatic drain_results();
    while (records_in_flight != 0 || expected_inserts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_table_size(input logic [SIZE_WIDTH-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender: bursts of beats separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_records.size() != 0) begin
        drive_rec = pending_records.pop_front();
        in_tdata  <= {drive_rec.pay, drive_rec.key};
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches among four modes at random intervals
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) table_size_q = cfg_data;
      if (in_tvalid && in_tready) begin
        in_took = 1'b1;
        expected_inserts.push_back(insert_record(in_tdata[KEY_WIDTH-1:0]));
        records_in_flight--;
      end
      if (out_tvalid && out_tready) begin
        got_status = out_tdata[STATUS_WIDTH-1:0];
        got_slot   = out_tdata[STATUS_WIDTH +: SLOT_WIDTH];
        got_probes = out_tdata[STATUS_WIDTH + SLOT_WIDTH +: PROBE_WIDTH];
        if (expected_inserts.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat: expected none, actual status %0d slot %0d probes %0d",
                   $time, got_status, got_slot, got_probes);
        end else begin
          want = expected_inserts.pop_front();
          if (got_status !== want.status || got_slot !== want.slot ||
              got_probes !== want.probes) begin
            error_count++;
            $display("%0t: insert mismatch: expected status %0d slot %0d probes %0d, actual status %0d slot %0d probes %0d",
                     $time, want.status, want.slot, want.probes,
                     got_status, got_slot, got_probes);
          end
        end
      end
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
          (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_linear_probe_hash_insert_core: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int i;
    int s;
    int empties;
    logic [SIZE_WIDTH-1:0] size_pick;
    logic [KEY_WIDTH-1:0]  key;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full-size table after reset: zero key, extreme keys, wrap, update
    queue_record(64'd0, $urandom);
    queue_record(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_record(64'd2047, 32'h0000_0000);
    queue_record(64'd1024, $urandom);
    queue_record(64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000);
    queue_record(64'd1, 32'h5555_5555);
    queue_record(64'h8000_0000_0000_0000, 32'hAAAA_AAAA);
    queue_record(64'd0, 32'hFFFF_FFFF);
    drain_results();

    // one-slot table: update in place, then full
    write_table_size(11'd1);
    queue_record(64'd2047, $urandom);
    queue_record(64'd5, $urandom);
    drain_results();

    // zero size behaves as one slot
    write_table_size(11'd0);
    queue_record(64'd7, $urandom);
    queue_record(64'd2047, $urandom);
    drain_results();

    // oversize clamps to the full depth
    write_table_size(11'h7FF);
    queue_record(64'd3, $urandom);
    queue_record(64'd1023, $urandom);
    drain_results();

    // small table already full, then shrink so slot 3 is hidden
    write_table_size(11'd4);
    queue_record(64'd6, $urandom);
    queue_record(64'd1, $urandom);
    drain_results();
    write_table_size(11'd3);
    queue_record(64'h8000_0000_0000_0000, $urandom);
    drain_results();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0:       size_pick = 11'd0;
        1:       size_pick = 11'd1;
        2:       size_pick = 11'h7FF;
        3:       size_pick = 11'd1024;
        4:       size_pick = 11'd1023;
        5:       size_pick = 11'($urandom_range(2, 2047));
        default: size_pick = 11'($urandom_range(1, 48));
      endcase
      write_table_size(size_pick);
      n = $urandom_range(20, 40);
      for (i = 0; i < n; i++) queue_record(random_key(), random_payload());
      drain_results();
    end

    // aim new keys at every empty slot until the table is full
    write_table_size(11'd1024);
    do begin
      empties = 0;
      for (s = 0; s < TABLE_DEPTH; s++) begin
        if (table_keys[s] == '0) begin
          key = {$urandom, $urandom};
          key[SLOT_WIDTH-1:0] = s[SLOT_WIDTH-1:0];
          if (key == '0) key[SLOT_WIDTH] = 1'b1;
          queue_record(key, random_payload());
          empties++;
          if ($urandom_range(0, 9) == 0) queue_record(random_key(), random_payload());
        end
      end
      drain_results();
    end while (empties != 0);

    // full table: saturated probe counts and updates
    for (i = 0; i < 12; i++) queue_record(random_key(), random_payload());
    drain_results();

    repeat (END_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_inserts.size() == 0) begin
      $display("tb_linear_probe_hash_insert_core: clean");
    end else begin
      $display("tb_linear_probe_hash_insert_core: errors");
    end
    $finish;
  end

endmodule
